@@ hdl/der_ecdsa_signature_parser_assert.svh @@
// Assertion macros used by the checker file of the DER signature parser.
`ifndef DER_ECDSA_SIGNATURE_PARSER_ASSERT_SVH
`define DER_ECDSA_SIGNATURE_PARSER_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define DESP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define DESP_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/desp_pkg.sv @@
// Package with the constants and types of the DER signature parser.
package desp_pkg;

  localparam int KEY_BYTES         = 32;
  localparam int MAX_LENGTH_OCTETS = 4;
  localparam int MAX_SIG_BYTES     = 256;

  localparam int STORE_BYTES = 2 * KEY_BYTES;
  localparam int ALL_WORDS   = (STORE_BYTES + 7) / 8;
  localparam int OUT_WORDS   = (ALL_WORDS > 8) ? 8 : ALL_WORDS;
  localparam int PAD_BYTES   = ALL_WORDS * 8;
  localparam int OUT_BYTES   = OUT_WORDS * 8;

  localparam int BC_W  = $clog2(MAX_SIG_BYTES + 2);
  localparam int LEN_W = 8 * MAX_LENGTH_OCTETS;
  localparam int SEO_W = ((LEN_W > BC_W) ? LEN_W : BC_W) + 1;
  localparam int IDX_W = $clog2(PAD_BYTES);
  localparam int OBI_W = $clog2(OUT_BYTES);
  localparam int LO_W  = 3;
  localparam int WIDX_W = 3;

  localparam int WORD_W  = 64;
  localparam int TDATA_W = ((WORD_W + WIDX_W + 7) / 8) * 8;

  localparam logic [7:0] SEQ_TAG = 8'h30;
  localparam logic [7:0] INT_TAG = 8'h02;

  typedef logic [OUT_BYTES-1:0][7:0] out_bytes_t;

  // Hand-over from the parser to the result buffer.
  typedef struct packed {
    logic load;
    logic ok;
  } snap_t;

endpackage

@@ hdl/desp_parser.sv @@
// Byte-serial DER parser: header state, value store and snapshot on the final byte.
module desp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output desp_pkg::snap_t     snap,
  output desp_pkg::out_bytes_t snap_data
);
  import desp_pkg::*;

  typedef enum logic [3:0] {
    PH_SEQ_TAG, PH_SEQ_LEN, PH_SEQ_LENX, PH_INT_TAG,
    PH_INT_LEN, PH_INT_LENX, PH_INT_VAL, PH_DONE
  } phase_t;

  phase_t             phase, phase_next;
  logic [BC_W-1:0]    byte_count, byte_count_next;
  logic [LEN_W-1:0]   length_accum, length_accum_next;
  logic [LO_W-1:0]    length_octets_left, length_octets_left_next;
  logic [SEO_W-1:0]   seq_end_offset, seq_end_offset_next;
  logic [LEN_W-1:0]   value_bytes_left, value_bytes_left_next;
  logic               second_integer, second_integer_next;
  logic               failed, failed_next;

  logic [PAD_BYTES-1:0][7:0] raw_store;
  logic [PAD_BYTES-1:0]      store_valid;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  logic [IDX_W:0]     idx_base;
  logic               len_known;
  logic [LEN_W-1:0]   len_value;
  logic [LEN_W-1:0]   accum_shift;
  logic [6:0]         octet_count;

  always_comb begin
    phase_next              = phase;
    length_accum_next       = length_accum;
    length_octets_left_next = length_octets_left;
    seq_end_offset_next     = seq_end_offset;
    value_bytes_left_next   = value_bytes_left;
    second_integer_next     = second_integer;
    wr_en                   = 1'b0;
    len_known               = 1'b0;
    len_value               = '0;
    octet_count             = in_byte[6:0];
    accum_shift             = LEN_W'({length_accum, in_byte});
    idx_base                = second_integer ? (IDX_W+1)'(2 * KEY_BYTES)
                                             : (IDX_W+1)'(KEY_BYTES);
    wr_idx                  = IDX_W'(idx_base - value_bytes_left[IDX_W:0]);

    // The count saturates one past the limit, which marks an overlong stream.
    byte_count_next = (byte_count <= BC_W'(MAX_SIG_BYTES)) ? byte_count + 1'b1
                                                           : byte_count;
    failed_next     = failed | (byte_count_next > BC_W'(MAX_SIG_BYTES));

    if (!failed_next) begin
      unique case (phase)
        PH_SEQ_TAG: begin
          if (in_byte != SEQ_TAG) failed_next = 1'b1;
          else phase_next = PH_SEQ_LEN;
        end
        PH_INT_TAG: begin
          if (in_byte != INT_TAG) failed_next = 1'b1;
          else phase_next = PH_INT_LEN;
        end
        PH_SEQ_LEN, PH_INT_LEN: begin
          if (!in_byte[7]) begin
            len_known = 1'b1;
            len_value = LEN_W'(in_byte);
          end else if (octet_count == 7'd0 ||
                       octet_count > 7'(MAX_LENGTH_OCTETS)) begin
            failed_next = 1'b1;
          end else begin
            length_octets_left_next = LO_W'(octet_count);
            length_accum_next       = '0;
            phase_next = (phase == PH_SEQ_LEN) ? PH_SEQ_LENX : PH_INT_LENX;
          end
        end
        PH_SEQ_LENX, PH_INT_LENX: begin
          length_accum_next       = accum_shift;
          length_octets_left_next = length_octets_left - 1'b1;
          if (length_octets_left_next == '0) begin
            len_known = 1'b1;
            len_value = accum_shift;
          end
        end
        PH_INT_VAL: begin
          value_bytes_left_next = value_bytes_left - 1'b1;
          if (value_bytes_left > LEN_W'(KEY_BYTES)) begin
            // Surplus leading bytes must be zero and are dropped.
            if (in_byte != 8'd0) begin
              failed_next           = 1'b1;
              value_bytes_left_next = value_bytes_left;
            end
          end else begin
            wr_en = 1'b1;
            if (value_bytes_left_next == '0) begin
              if (second_integer) begin
                if (SEO_W'(byte_count_next) != seq_end_offset) failed_next = 1'b1;
                else phase_next = PH_DONE;
              end else begin
                second_integer_next = 1'b1;
                phase_next          = PH_INT_TAG;
              end
            end
          end
        end
        default: begin
        end
      endcase

      if (len_known) begin
        if (phase == PH_SEQ_LEN || phase == PH_SEQ_LENX) begin
          seq_end_offset_next = SEO_W'(byte_count_next) + SEO_W'(len_value);
          phase_next          = PH_INT_TAG;
        end else if (len_value == '0) begin
          failed_next = 1'b1;
        end else begin
          value_bytes_left_next = len_value;
          phase_next            = PH_INT_VAL;
        end
      end
    end

    if (in_last && phase_next != PH_DONE) failed_next = 1'b1;
  end

  // The snapshot sees the byte written in this same cycle.
  always_comb begin
    for (int i = 0; i < OUT_BYTES; i++) begin
      if (wr_en && wr_idx == IDX_W'(i)) snap_data[i] = in_byte;
      else if (store_valid[i]) snap_data[i] = raw_store[i];
      else snap_data[i] = 8'd0;
    end
    snap.load = take & in_last;
    snap.ok   = ~failed_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && in_last)) begin
      phase              <= PH_SEQ_TAG;
      byte_count         <= '0;
      length_accum       <= '0;
      length_octets_left <= '0;
      seq_end_offset     <= '0;
      value_bytes_left   <= '0;
      second_integer     <= 1'b0;
      failed             <= 1'b0;
      store_valid        <= '0;
    end else if (take) begin
      phase              <= phase_next;
      byte_count         <= byte_count_next;
      length_accum       <= length_accum_next;
      length_octets_left <= length_octets_left_next;
      seq_end_offset     <= seq_end_offset_next;
      value_bytes_left   <= value_bytes_left_next;
      second_integer     <= second_integer_next;
      failed             <= failed_next;
      if (wr_en) store_valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && wr_en) raw_store[wr_idx] <= in_byte;
  end

endmodule

@@ hdl/desp_out.sv @@
// Result buffer and word sequencer that sends r||s, or a failure, downstream.
module desp_out (
  input  logic                         clk,
  input  logic                         rst,
  input  desp_pkg::snap_t              snap,
  input  desp_pkg::out_bytes_t         snap_data,
  output logic                         busy,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [desp_pkg::TDATA_W-1:0] m_tdata,
  output logic                         m_tlast,
  output logic                         m_tuser
);
  import desp_pkg::*;

  out_bytes_t        result_buf;
  logic              ok_r;
  logic [WIDX_W-1:0] word_cnt;
  logic [WORD_W-1:0] word;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      word[WORD_W-1-8*k -: 8] = result_buf[OBI_W'({word_cnt, 3'(k)})];
    end
    m_tvalid = busy;
    m_tlast  = ~ok_r | (word_cnt == WIDX_W'(OUT_WORDS - 1));
    m_tuser  = ok_r;
    m_tdata  = ok_r ? TDATA_W'({word_cnt, word}) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      word_cnt <= '0;
      ok_r     <= 1'b0;
    end else if (snap.load) begin
      busy     <= 1'b1;
      word_cnt <= '0;
      ok_r     <= snap.ok;
    end else if (busy && m_tready) begin
      if (m_tlast) busy <= 1'b0;
      else word_cnt <= word_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (snap.load) result_buf <= snap_data;
  end

endmodule

@@ hdl/der_ecdsa_signature_parser.sv @@
// Top level of the DER-encoded ECDSA signature parser.
// The block takes a DER-encoded ECDSA signature one byte per transaction on
// the slave channel, with s_tlast high on the final byte of the signature.
// It checks the SEQUENCE header and the two INTEGERs r and s and collects
// their values, right-aligned and zero-padded, in an internal byte store.
// Every byte is handled in the cycle it is accepted, so one byte per cycle is
// taken while the sender supplies them, unless a final byte has to wait.
// The edge that accepts the final byte also copies the outcome into a result
// buffer, and the first result is offered in the cycle after that final byte.
// A good signature yields eight 64-bit words of r||s, big-endian, one word
// per cycle while the receiver is ready, with the word index in tdata, tlast on
// the last word and tuser (ok) high. A failed signature yields one transaction
// with zero data, tlast high and tuser low.
// Ordinary bytes keep being accepted while the result buffer drains; only a
// final byte waits (s_tready low) while earlier results are still being sent.
// It may enter in the cycle in which the last of them is taken, so a stalled
// receiver holds back the next signature at its last byte and no longer.
// Reset clears the parser state and empties the result buffer; the byte store
// needs no clearing pass, as its entries carry valid bits.
module der_ecdsa_signature_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] sig_byte
  input  logic                         s_tlast,   // last_byte
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [desp_pkg::TDATA_W-1:0] m_tdata,   // [63:0] raw_word, [66:64] word_index
  output logic                         m_tlast,   // last_word
  output logic                         m_tuser    // ok
);
  import desp_pkg::*;

  snap_t      snap;
  out_bytes_t snap_data;
  logic       busy;
  logic       take;

  // A final byte needs a result buffer that is free or frees up in this
  // cycle; other bytes always go in.
  assign s_tready = ~busy | ~s_tlast | (m_tready & m_tlast);
  assign take     = s_tvalid & s_tready;

  desp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .snap      (snap),
    .snap_data (snap_data)
  );

  desp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .snap      (snap),
    .snap_data (snap_data),
    .busy      (busy),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

@@ hdl/desp_checker.sv @@
// Port-level checker for the DER signature parser, bound to the top level.
`include "der_ecdsa_signature_parser_assert.svh"

module desp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic [7:0]                   s_tdata,
  input logic                         s_tlast,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [desp_pkg::TDATA_W-1:0] m_tdata,
  input logic                         m_tlast,
  input logic                         m_tuser
);
  import desp_pkg::*;

  `DESP_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
  `DESP_ASSERT(a_fail, clk, rst, m_tvalid && !m_tuser |-> m_tlast && m_tdata == '0, "failure result is not a single zero word")
  `DESP_ASSERT(a_lastidx, clk, rst, m_tvalid && m_tuser && m_tlast |-> m_tdata[66:64] == 3'(OUT_WORDS - 1), "good signature ends on wrong word")
  `DESP_ASSERT(a_step, clk, rst, m_tvalid && m_tready && m_tuser && !m_tlast |=> m_tvalid && m_tuser && m_tdata[66:64] == $past(m_tdata[66:64]) + 3'd1, "word index does not advance")
  `DESP_ASSERT_RST(a_reset, clk, rst |=> !m_tvalid, "result offered straight after reset")

endmodule

bind der_ecdsa_signature_parser desp_checker u_desp_checker (.*);

@@ bench/tb_top.sv @@
// Self-checking testbench for the byte-serial DER ECDSA signature parser.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import desp_pkg::*;

  // First length byte: the top bit selects the long form and the low seven bits
  // then give the number of length octets that follow.
  localparam logic [7:0] LONG_FORM = 8'h80;
  localparam logic [7:0] LEN_MASK  = 8'h7F;

  // How far the parser has got through the current signature.
  typedef enum logic [3:0] {
    PH_SEQ_TAG, PH_SEQ_LEN, PH_SEQ_LENX, PH_INT_TAG,
    PH_INT_LEN, PH_INT_LENX, PH_INT_VAL, PH_DONE
  } parse_ph_t;

  // One word of r||s as it leaves the master side.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [WIDX_W-1:0] idx;
    logic              last;
    logic              ok;
  } sig_word_t;

  // The single transaction that reports a rejected signature.
  localparam sig_word_t REJECT_WORD = '{word: '0, idx: '0, last: 1'b1, ok: 1'b0};

  // A directed byte; reject marks a final byte whose outcome is obviously a
  // rejection, so that the expectation is typed in rather than predicted.
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       reject;
  } dir_row_t;

  localparam int N_DIR = 22;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // Wrong SEQUENCE tag on a lone final byte.
    '{SEQ_TAG ^ 8'h01, 1'b1, 1'b1},
    // Cut off straight after the SEQUENCE tag.
    '{SEQ_TAG, 1'b1, 1'b1},
    // Long form that announces no length octets at all.
    '{SEQ_TAG, 1'b0, 1'b0}, '{LONG_FORM, 1'b1, 1'b1},
    // Long form that announces more length octets than are supported.
    '{SEQ_TAG, 1'b0, 1'b0}, '{LONG_FORM | 8'h05, 1'b1, 1'b1},
    // Smallest good signature with extreme value bytes, then one trailing
    // byte that must be ignored.
    '{SEQ_TAG, 1'b0, 1'b0}, '{8'h06, 1'b0, 1'b0},
    '{INT_TAG, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0},
    '{INT_TAG, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0},
    '{8'hFF, 1'b1, 1'b0},
    // INTEGER with a length of zero.
    '{SEQ_TAG, 1'b0, 1'b0}, '{8'h02, 1'b0, 1'b0},
    '{INT_TAG, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b1},
    // Empty SEQUENCE followed by something that is not an INTEGER tag.
    '{SEQ_TAG, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'h05, 1'b1, 1'b1}
  };

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata  = 8'h00;  // [7:0] sig_byte
  logic                s_tlast  = 1'b0;   // last_byte
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;           // [63:0] raw_word, [66:64] word_index
  logic                m_tlast;           // last_word
  logic                m_tuser;           // ok

  // Mirror of the parser state, stepped on every accepted byte.
  parse_ph_t   ph;
  int unsigned n_bytes;
  logic [31:0] len_acc;
  logic [2:0]  oct_left;
  logic [32:0] seq_end;
  logic [31:0] val_left;
  bit          on_s;
  bit          sig_bad;
  logic [7:0]  rs_store [STORE_BYTES];

  sig_word_t   step_words [OUT_WORDS];   // words produced by the latest byte
  sig_word_t   words_due [$];            // words still to come out, oldest first
  logic [7:0]  sig_q [$];                // signature being assembled for sending
  sig_word_t   got;

  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit clean   = 1'b0;   // when set, generated signatures are always well formed
  int rx_hold = 0;
  int errors  = 0;
  int n_sent  = 0;
  int n_sigs  = 0;
  int n_words = 0;
  int n_good  = 0;
  int n_rej   = 0;

  der_ecdsa_signature_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Idle stretch: mostly none or short, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void reset_parser();
    ph       = PH_SEQ_TAG;
    n_bytes  = 0;
    len_acc  = '0;
    oct_left = '0;
    seq_end  = '0;
    val_left = '0;
    on_s     = 1'b0;
    sig_bad  = 1'b0;
    for (int i = 0; i < STORE_BYTES; i++) rs_store[i] = 8'h00;
  endfunction

  // A complete length is known: it either fixes where the SEQUENCE ends or
  // opens the value of an INTEGER.
  function automatic void length_known(input logic [31:0] len);
    if (ph == PH_SEQ_LEN || ph == PH_SEQ_LENX) begin
      seq_end = 33'(n_bytes) + 33'(len);
      ph      = PH_INT_TAG;
    end else if (len == 0) begin
      sig_bad = 1'b1;
    end else begin
      val_left = len;
      ph       = PH_INT_VAL;
    end
  endfunction

  // Steps the mirror by one byte and returns how many words it produces;
  // the words themselves are left in step_words.
  function automatic int decode_sig_byte(input logic [7:0] b, input logic last);
    int          idx;
    logic [63:0] v;
    if (n_bytes <= MAX_SIG_BYTES) n_bytes++;
    if (n_bytes > MAX_SIG_BYTES) sig_bad = 1'b1;
    if (!sig_bad) begin
      case (ph)
        PH_SEQ_TAG: begin
          if (b != SEQ_TAG) sig_bad = 1'b1;
          else ph = PH_SEQ_LEN;
        end
        PH_INT_TAG: begin
          if (b != INT_TAG) sig_bad = 1'b1;
          else ph = PH_INT_LEN;
        end
        PH_SEQ_LEN, PH_INT_LEN: begin
          if ((b & LONG_FORM) == 0) begin
            length_known({24'd0, b});
          end else if ((b & LEN_MASK) == 0 || (b & LEN_MASK) > MAX_LENGTH_OCTETS) begin
            sig_bad = 1'b1;
          end else begin
            oct_left = b[2:0];
            len_acc  = '0;
            ph       = (ph == PH_SEQ_LEN) ? PH_SEQ_LENX : PH_INT_LENX;
          end
        end
        PH_SEQ_LENX, PH_INT_LENX: begin
          len_acc  = {len_acc[23:0], b};
          oct_left = oct_left - 3'd1;
          if (oct_left == 0) length_known(len_acc);
        end
        PH_INT_VAL: begin
          if (val_left > 32'(KEY_BYTES)) begin
            // Surplus leading bytes may only be zero padding.
            if (b != 8'h00) sig_bad = 1'b1;
            else val_left = val_left - 1;
          end else begin
            idx = (on_s ? KEY_BYTES : 0) + KEY_BYTES - int'(val_left);
            if (idx < STORE_BYTES) rs_store[idx] = b;
            val_left = val_left - 1;
            if (val_left == 0) begin
              if (!on_s) begin
                on_s = 1'b1;
                ph   = PH_INT_TAG;
              end else if (33'(n_bytes) != seq_end) begin
                sig_bad = 1'b1;
              end else begin
                ph = PH_DONE;
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (!last) return 0;
    if (ph != PH_DONE) sig_bad = 1'b1;
    if (sig_bad) begin
      step_words[0] = REJECT_WORD;
      reset_parser();
      return 1;
    end
    for (int w = 0; w < OUT_WORDS; w++) begin
      v = '0;
      for (int k = 0; k < 8; k++) v = {v[55:0], rs_store[w * 8 + k]};
      step_words[w] = '{word: v, idx: WIDX_W'(w), last: (w == OUT_WORDS - 1), ok: 1'b1};
    end
    reset_parser();
    return OUT_WORDS;
  endfunction

  // Appends a length in short or long form; wreck gives an illegal long form.
  function automatic void put_len(input logic [31:0] len, input bit wreck);
    int n;
    if (wreck) begin
      sig_q.push_back($urandom_range(0, 1) ? LONG_FORM
                      : (LONG_FORM | 8'($urandom_range(MAX_LENGTH_OCTETS + 1, 127))));
      return;
    end
    if (len < 128 && $urandom_range(0, 3) != 0) begin
      sig_q.push_back(len[7:0]);
      return;
    end
    n = (len > 32'hFF_FFFF) ? 4 : (len > 32'hFFFF) ? 3 : (len > 32'hFF) ? 2 : 1;
    n = $urandom_range(n, MAX_LENGTH_OCTETS);
    sig_q.push_back(LONG_FORM | 8'(n));
    for (int k = n - 1; k >= 0; k--) sig_q.push_back(8'(len >> (8 * k)));
  endfunction

  // Appends one INTEGER; most are well formed, a few are broken in one way.
  function automatic void put_int();
    int pick;
    int len;
    int pad;
    int r;
    pick = clean ? 99 : $urandom_range(0, 99);
    sig_q.push_back(pick < 3 ? INT_TAG ^ (8'h01 << $urandom_range(0, 7)) : INT_TAG);
    if (pick >= 3 && pick < 6) begin
      put_len(32'd0, 1'b0);
      return;
    end
    if (pick >= 6 && pick < 8) begin
      put_len(32'd0, 1'b1);
      return;
    end
    if (pick >= 8 && pick < 10) begin
      // A huge length; the stream ends long before it is used up.
      put_len($urandom | 32'h100, 1'b0);
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 75) len = $urandom_range(1, 4);
    else if (r < 90) len = $urandom_range(KEY_BYTES - 4, KEY_BYTES);
    else len = $urandom_range(KEY_BYTES + 1, KEY_BYTES + 3);
    put_len(32'(len), 1'b0);
    pad = len - KEY_BYTES;
    for (int i = 0; i < len; i++) begin
      if (i < pad)
        sig_q.push_back((i == 0 && !clean && $urandom_range(0, 3) == 0)
                        ? 8'($urandom_range(1, 255)) : 8'h00);
      else
        sig_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Assembles a whole signature in sig_q, sometimes spoilt in the header,
  // with trailing bytes, or cut short.
  function automatic void build_sig();
    logic [7:0]  body [$];
    logic [31:0] seq_len;
    int          pick;
    int          cut;
    sig_q.delete();
    put_int();
    put_int();
    for (int i = 0; i < sig_q.size(); i++) body.push_back(sig_q[i]);
    sig_q.delete();
    pick = clean ? 99 : $urandom_range(0, 99);
    sig_q.push_back(pick < 3 ? 8'($urandom_range(0, 255)) : SEQ_TAG);
    seq_len = 32'(body.size());
    if (pick >= 6 && pick < 14) begin
      if ($urandom_range(0, 1) == 0) seq_len = seq_len + $urandom_range(1, 3);
      else seq_len = seq_len - 1;
    end
    put_len(seq_len, pick >= 3 && pick < 6);
    for (int i = 0; i < body.size(); i++) sig_q.push_back(body[i]);
    if (!clean && $urandom_range(0, 99) < 15)
      repeat ($urandom_range(1, 4)) sig_q.push_back(8'($urandom_range(0, 255)));
    if (!clean && $urandom_range(0, 99) < 6 && sig_q.size() > 1) begin
      cut = $urandom_range(1, sig_q.size() - 1);
      while (sig_q.size() > cut) sig_q.pop_back();
    end
  endfunction

  // Offers one byte after a random idle stretch, waits for the transaction
  // and then steps the mirror.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic reject);
    int idle;
    int n;
    idle = tx_calm ? 0 : gap_len();
    if (idle > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (idle - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    n = decode_sig_byte(b, last);
    if (reject) words_due.push_back(REJECT_WORD);
    else for (int i = 0; i < n; i++) words_due.push_back(step_words[i]);
    n_sent++;
    if (last) n_sigs++;
  endtask

  task automatic send_sig();
    tx_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < sig_q.size(); i++) send_byte(sig_q[i], i == sig_q.size() - 1, 1'b0);
  endtask

  // The receiver stalls in random stretches, and now and then spends a long
  // while without stalling at all.
  always @(negedge clk) begin
    if ($urandom_range(0, 149) == 0) rx_calm = !rx_calm;
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      m_tready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 2) == 0) rx_hold = gap_len();
    end
  end

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] seen);
    if (want !== seen) begin
      errors++;
      if (errors <= 40)
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
    end
  endfunction

  // Every transaction on the master side is held against the oldest word due.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = '{word: m_tdata[WORD_W-1:0], idx: m_tdata[WORD_W +: WIDX_W],
              last: m_tlast, ok: m_tuser};
      n_words++;
      if (got.last) begin
        if (got.ok) n_good++;
        else n_rej++;
      end
      if (words_due.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t ns: unexpected result, expected none, got %0h", $time, got);
      end else begin
        check_field("raw_word", words_due[0].word, got.word);
        check_field("word_index", 64'(words_due[0].idx), 64'(got.idx));
        check_field("last_word", 64'(words_due[0].last), 64'(got.last));
        check_field("ok", 64'(words_due[0].ok), 64'(got.ok));
        void'(words_due.pop_front());
      end
    end
  end

  initial begin
    reset_parser();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table first.
    for (int i = 0; i < N_DIR; i++)
      send_byte(DIR_ROWS[i].b, DIR_ROWS[i].last, DIR_ROWS[i].reject);

    // Random signatures, every fourth one well formed by construction, most
    // of the others well formed too and a few plain noise.
    for (int s = 0; n_sent < 110; s++) begin
      clean = (s % 4 == 0);
      if (!clean && $urandom_range(0, 99) < 8) begin
        sig_q.delete();
        repeat ($urandom_range(1, 12)) sig_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_sig();
      end
      send_sig();
    end
    clean = 1'b0;

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes in %0d signatures; %0d words checked, %0d parsed, %0d rejected.",
             n_sent, n_sigs, n_words, n_good, n_rej);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches found.", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #8_000_000;
    $display("Timed out with %0d words still due.", words_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
